@@ hw/rtl/bpa_pkg.sv @@
package bpa_pkg;

  localparam int MAX_PAGES  = 1024;
  localparam int PAGE_SHIFT = 12;

  localparam int ADDR_W     = 32;
  localparam int CNT_W      = 11;
  localparam int BASE_W     = 20;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = BASE_W;

  localparam int WORD_W  = 32;
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int NWORDS  = MAX_PAGES / WORD_W;
  localparam int WIDX_W  = $clog2(NWORDS);
  localparam int PIDX_W  = $clog2(MAX_PAGES);
  localparam int OPG_W   = ADDR_W - PAGE_SHIFT;
  localparam int RUN_W   = CNT_W + 1;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_READY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_COUNT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNALIGNED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RANGE       = 3'd5;
  localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE = 3'd6;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_READY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES = 2'd2;

  localparam logic [1:0] OP_SCAN  = 2'd0;
  localparam logic [1:0] OP_CHECK = 2'd1;
  localparam logic [1:0] OP_SET   = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  typedef struct packed {
    logic                load;
    logic                pre;
    logic                start;
    logic [1:0]          op;
    logic                out_load;
    logic [STATUS_W-1:0] out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic not_ready;
    logic bad_count;
    logic is_free;
    logic unaligned;
    logic out_of_range;
    logic busy;
    logic done;
    logic flag;
  } dp_sts_t;

endpackage

@@ hw/rtl/bpa_req_if.sv @@
interface bpa_req_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [CNT_W-1:0]  num_pages;
  logic [ADDR_W-1:0] free_address;

  modport source (output valid, output action, output num_pages, output free_address,
                  input ready);
  modport sink (input valid, input action, input num_pages, input free_address,
                output ready);
endinterface

@@ hw/rtl/bpa_rsp_if.sv @@
interface bpa_rsp_if import bpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   result_address;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output result_address, output status, input ready);
  modport sink (input valid, input result_address, input status, output ready);
endinterface

@@ hw/rtl/bitmap_page_allocator.sv @@
// First-fit contiguous page allocator over a bitmap of 1024 pages held as 32-bit words in a
// small RAM, one word read per cycle. A request is loaded, prechecked and evaluated first. An
// allocate then scans the bitmap up to the word where the first fitting run ends, sets up the
// mark, marks each word the run spans and posts the result. A free checks that every page in
// its range is taken, clears the run and posts the result. Failed checks go straight to the
// post step. The result sits in an output register, so the next request is taken while it
// waits; a finished request holds in its post cycle until that register is free. The bitmap
// reads as all free right after reset (per-word valid flags, no clearing pass).
// Configuration must be written only while idle; the block itself does not enforce this.
module bitmap_page_allocator import bpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  bpa_req_if.sink               in_req,
  bpa_rsp_if.source             out_rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (dp_cmd),
    .sts       (dp_sts)
  );

  bpa_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_action          (in_req.action),
    .in_num_pages       (in_req.num_pages),
    .in_free_address    (in_req.free_address),
    .cmd                (dp_cmd),
    .sts                (dp_sts),
    .out_result_address (out_rsp.result_address),
    .out_status         (out_rsp.status)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> !in_req.ready)
    else $error("request taken while previous one in work");

  a_stream_starts: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.start |=> dp_sts.busy && !dp_sts.done)
    else $error("bitmap stream did not start cleanly");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && out_rsp.status != ST_OK |-> out_rsp.result_address == '0)
    else $error("failed request carries a nonzero address");

  a_load_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.out_load |-> !dp_sts.busy)
    else $error("result posted while bitmap stream active");
`endif

endmodule

@@ hw/rtl/bpa_ram.sv @@
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/bpa_datapath.sv @@
module bpa_datapath import bpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_action,
  input  logic [CNT_W-1:0]      in_num_pages,
  input  logic [ADDR_W-1:0]     in_free_address,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  output logic [ADDR_W-1:0]     out_result_address,
  output logic [STATUS_W-1:0]   out_status
);

  // configuration
  logic              ready_cfg_r;
  logic [BASE_W-1:0] base_page_r;
  logic [CNT_W-1:0]  pages_r;

  // request
  logic              action_r;
  logic [CNT_W-1:0]  count_r;
  logic [ADDR_W-1:0] addr_r;

  // free prechecks
  logic              borrow_r;
  logic [OPG_W-1:0]  off_page_r;

  // word stream
  logic [1:0]        op_r;
  logic [PIDX_W-1:0] lo_r, hi_r;
  logic              rd_act_r, rd_act_nxt;
  logic [WIDX_W-1:0] rd_w_r, rd_w_nxt;
  logic              pv_r, pv_nxt;
  logic [WIDX_W-1:0] pw_r, pw_nxt;
  logic              rowv_q_r, rowv_nxt;
  logic [CNT_W-1:0]  run_r;
  logic [PIDX_W-1:0] found_r;
  logic [NWORDS-1:0] row_valid_r;

  logic [ADDR_W-1:0]   out_addr_r;
  logic [STATUS_W-1:0] out_status_r;

  logic [CNT_W-1:0]    eff_cnt, eff_cnt_m1, cnt_m1;
  logic [ADDR_W-1:0]   base_addr, alloc_addr;
  logic [ADDR_W:0]     diff;
  logic [PIDX_W-1:0]   chk_start, new_lo, new_hi;
  logic [WIDX_W-1:0]   lo_word, hi_word;
  logic [WORD_W-1:0]   ram_rdata, q_eff, lo_mask, hi_mask, mask, busy_bits, wr_data;
  logic                ram_we;
  logic [RUN_W-1:0]    run_v [WORD_W];
  logic                hit_any;
  logic [BIT_W-1:0]    hit_idx;
  logic [RUN_W-1:0]    gstart;
  logic                all_set, last_word, done;

  assign eff_cnt    = (pages_r > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : pages_r;
  assign eff_cnt_m1 = eff_cnt - CNT_W'(1);
  assign cnt_m1     = count_r - CNT_W'(1);
  assign base_addr  = ADDR_W'({base_page_r, {PAGE_SHIFT{1'b0}}});
  assign alloc_addr = base_addr + ADDR_W'({found_r, {PAGE_SHIFT{1'b0}}});
  assign diff       = {1'b0, addr_r} - {1'b0, base_addr};
  assign chk_start  = off_page_r[PIDX_W-1:0];
  assign lo_word    = lo_r[PIDX_W-1:BIT_W];
  assign hi_word    = hi_r[PIDX_W-1:BIT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_cfg_r <= 1'b0;
      base_page_r <= '0;
      pages_r     <= CNT_W'(MAX_PAGES);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_READY: ready_cfg_r <= cfg_wdata[0];
        CFG_BASE:  base_page_r <= cfg_wdata[BASE_W-1:0];
        CFG_PAGES: pages_r     <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      count_r  <= in_num_pages;
      addr_r   <= in_free_address;
    end
    if (cmd.pre) begin
      borrow_r   <= diff[ADDR_W];
      off_page_r <= diff[ADDR_W-1:PAGE_SHIFT];
    end
  end

  assign sts.not_ready    = !ready_cfg_r;
  assign sts.bad_count    = (count_r == '0) || (count_r > eff_cnt);
  assign sts.is_free      = (action_r == ACT_FREE);
  assign sts.unaligned    = (addr_r[PAGE_SHIFT-1:0] != '0);
  assign sts.out_of_range = borrow_r || (off_page_r >= OPG_W'(eff_cnt)) ||
                            ((OPG_W+1)'(off_page_r) + (OPG_W+1)'(count_r) >
                             (OPG_W+1)'(eff_cnt));

  // range of the next stream
  always_comb begin
    case (cmd.op)
      OP_SCAN: begin
        new_lo = '0;
        new_hi = eff_cnt_m1[PIDX_W-1:0];
      end
      OP_SET: begin
        new_lo = found_r;
        new_hi = found_r + cnt_m1[PIDX_W-1:0];
      end
      default: begin
        new_lo = chk_start;
        new_hi = chk_start + cnt_m1[PIDX_W-1:0];
      end
    endcase
  end

  // word processing
  always_comb begin
    logic             any;
    logic [BIT_W-1:0] ls;
    q_eff     = rowv_q_r ? ram_rdata : '0;
    lo_mask   = (pw_r == lo_word) ? ({WORD_W{1'b1}} << lo_r[BIT_W-1:0]) : '1;
    hi_mask   = (pw_r == hi_word) ?
                ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi_r[BIT_W-1:0])) : '1;
    mask      = lo_mask & hi_mask;
    busy_bits = q_eff | ~mask;
    for (int i = 0; i < WORD_W; i++) begin
      any = 1'b0;
      ls  = '0;
      for (int j = 0; j < WORD_W; j++) begin
        if (j <= i && busy_bits[j]) begin
          any = 1'b1;
          ls  = BIT_W'(j);
        end
      end
      run_v[i] = any ? (RUN_W'(i) - RUN_W'(ls)) : (RUN_W'(run_r) + RUN_W'(i + 1));
    end
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (!hit_any && run_v[i] >= RUN_W'(count_r)) begin
        hit_any = 1'b1;
        hit_idx = BIT_W'(i);
      end
    end
    gstart    = RUN_W'({pw_r, hit_idx}) + RUN_W'(1) - RUN_W'(count_r);
    all_set   = ((q_eff & mask) == mask);
    last_word = (pw_r == hi_word);
    wr_data   = (op_r == OP_SET) ? (q_eff | mask) : (q_eff & ~mask);
    ram_we    = pv_r && (op_r == OP_SET || op_r == OP_CLEAR);
    done      = pv_r && (last_word || (op_r == OP_SCAN && hit_any) ||
                         (op_r == OP_CHECK && !all_set));
  end

  assign sts.busy = rd_act_r || pv_r;
  assign sts.done = done;
  assign sts.flag = (op_r == OP_SCAN) ? hit_any : ((op_r == OP_CHECK) ? all_set : 1'b1);

  // read issue one word per cycle, each word processed in the cycle after its read
  always_comb begin
    rd_act_nxt = rd_act_r;
    rd_w_nxt   = rd_w_r;
    pv_nxt     = 1'b0;
    pw_nxt     = pw_r;
    rowv_nxt   = rowv_q_r;
    if (rd_act_r) begin
      pv_nxt   = 1'b1;
      pw_nxt   = rd_w_r;
      rowv_nxt = row_valid_r[rd_w_r];
      if (rd_w_r == hi_word) begin
        rd_act_nxt = 1'b0;
      end else begin
        rd_w_nxt = rd_w_r + WIDX_W'(1);
      end
    end
    if (done) begin
      rd_act_nxt = 1'b0;
      pv_nxt     = 1'b0;
    end
    if (cmd.start) begin
      rd_act_nxt = 1'b1;
      rd_w_nxt   = new_lo[PIDX_W-1:BIT_W];
      pv_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_act_r    <= 1'b0;
      pv_r        <= 1'b0;
      row_valid_r <= '0;
    end else begin
      rd_act_r <= rd_act_nxt;
      pv_r     <= pv_nxt;
      if (ram_we) begin
        row_valid_r[pw_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_w_r   <= rd_w_nxt;
    pw_r     <= pw_nxt;
    rowv_q_r <= rowv_nxt;
    if (cmd.start) begin
      op_r  <= cmd.op;
      lo_r  <= new_lo;
      hi_r  <= new_hi;
      run_r <= '0;
    end else if (pv_r && op_r == OP_SCAN) begin
      run_r <= run_v[WORD_W-1][CNT_W-1:0];
    end
    if (pv_r && op_r == OP_SCAN && hit_any) begin
      found_r <= gstart[PIDX_W-1:0];
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_addr_r   <= (cmd.out_status == ST_OK && action_r == ACT_ALLOC) ? alloc_addr : '0;
    end
  end

  bpa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NWORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pw_r),
    .wdata (wr_data),
    .raddr (rd_w_r),
    .rdata (ram_rdata)
  );

  assign out_result_address = out_addr_r;
  assign out_status         = out_status_r;

endmodule

@@ hw/rtl/bpa_ctrl.sv @@
module bpa_ctrl import bpa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRE   = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_MARK  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;
  localparam logic [2:0] S_ARM   = 3'd7;

  logic [2:0]          state_r, state_nxt;
  logic [STATUS_W-1:0] st_r, st_nxt;
  logic                out_valid_r, out_valid_nxt;

  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = S_PRE;
        end
      end
      S_PRE: begin
        cmd.pre   = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (sts.not_ready) begin
          st_nxt    = ST_NOT_READY;
          state_nxt = S_DONE;
        end else if (sts.bad_count) begin
          st_nxt    = ST_BAD_COUNT;
          state_nxt = S_DONE;
        end else if (!sts.is_free) begin
          cmd.start = 1'b1;
          cmd.op    = OP_SCAN;
          state_nxt = S_SCAN;
        end else if (sts.unaligned) begin
          st_nxt    = ST_UNALIGNED;
          state_nxt = S_DONE;
        end else if (sts.out_of_range) begin
          st_nxt    = ST_RANGE;
          state_nxt = S_DONE;
        end else begin
          cmd.start = 1'b1;
          cmd.op    = OP_CHECK;
          state_nxt = S_CHECK;
        end
      end
      S_SCAN: begin
        if (sts.done) begin
          if (sts.flag) begin
            st_nxt    = ST_OK;
            state_nxt = S_ARM;
          end else begin
            st_nxt    = ST_NO_SPACE;
            state_nxt = S_DONE;
          end
        end
      end
      S_ARM: begin
        cmd.start = 1'b1;
        cmd.op    = OP_SET;
        state_nxt = S_MARK;
      end
      S_CHECK: begin
        if (sts.done) begin
          if (sts.flag) begin
            cmd.start = 1'b1;
            cmd.op    = OP_CLEAR;
            st_nxt    = ST_OK;
            state_nxt = S_MARK;
          end else begin
            st_nxt    = ST_DOUBLE_FREE;
            state_nxt = S_DONE;
          end
        end
      end
      S_MARK: begin
        if (sts.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = st_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

endmodule

@@ sim/page_alloc_checker.sv @@
`timescale 1ns / 100ps

module page_alloc_checker import bpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_valid,
  input  logic                  req_ready,
  input  logic                  req_action,
  input  logic [CNT_W-1:0]      req_num_pages,
  input  logic [ADDR_W-1:0]     req_free_address,
  input  logic                  rsp_valid,
  input  logic                  rsp_ready,
  input  logic [ADDR_W-1:0]     rsp_result_address,
  input  logic [STATUS_W-1:0]   rsp_status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    results_checked,
  output logic [7:0]            status_seen
);

  typedef struct packed {
    logic [ADDR_W-1:0]   address;
    logic [STATUS_W-1:0] status;
  } page_result_t;

  page_result_t         expected_results[$];
  logic [MAX_PAGES-1:0] page_taken;
  logic                 alloc_enabled;
  logic [BASE_W-1:0]    base_frame;
  logic [CNT_W-1:0]     region_pages;

  function automatic page_result_t predict_page_request(input logic act,
                                                        input logic [CNT_W-1:0] n,
                                                        input logic [ADDR_W-1:0] addr);
    page_result_t      res;
    int unsigned       limit;
    int unsigned       run;
    int                first;
    int                i;
    longint            start;
    logic [ADDR_W-1:0] base;
    logic              all_taken;
    res.address = '0;
    res.status  = ST_OK;
    limit = (region_pages > MAX_PAGES) ? MAX_PAGES : region_pages;
    base  = ADDR_W'(base_frame) << PAGE_SHIFT;
    if (!alloc_enabled) begin
      res.status = ST_NOT_READY;
    end else if (n == 0 || n > limit) begin
      res.status = ST_BAD_COUNT;
    end else if (act == ACT_ALLOC) begin
      run   = 0;
      first = -1;
      for (i = 0; i < limit; i++) begin
        if (first < 0) begin
          if (page_taken[i]) begin
            run = 0;
          end else begin
            run++;
            if (run == n) first = i + 1 - n;
          end
        end
      end
      if (first < 0) begin
        res.status = ST_NO_SPACE;
      end else begin
        for (i = first; i < first + n; i++) page_taken[i] = 1'b1;
        res.address = base + (ADDR_W'(first) << PAGE_SHIFT);
      end
    end else begin
      if (addr[PAGE_SHIFT-1:0] != '0) begin
        res.status = ST_UNALIGNED;
      end else if (addr < base) begin
        res.status = ST_RANGE;
      end else begin
        start = longint'((addr - base) >> PAGE_SHIFT);
        if (start >= limit || start + n > limit) begin
          res.status = ST_RANGE;
        end else begin
          all_taken = 1'b1;
          for (i = 0; i < n; i++) begin
            if (!page_taken[start + i]) all_taken = 1'b0;
          end
          if (!all_taken) begin
            res.status = ST_DOUBLE_FREE;
          end else begin
            for (i = 0; i < n; i++) page_taken[start + i] = 1'b0;
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch_channels
    page_result_t exp_res;
    if (!rst_n) begin
      expected_results.delete();
      page_taken      = '0;
      alloc_enabled   = 1'b0;
      base_frame      = '0;
      region_pages    = CNT_W'(MAX_PAGES);
      fail_count      = 0;
      results_checked = 0;
      status_seen     = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_READY: alloc_enabled = cfg_wdata[0];
          CFG_BASE:  base_frame = cfg_wdata[BASE_W-1:0];
          CFG_PAGES: region_pages = cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        results_checked++;
        status_seen[rsp_status] = 1'b1;
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: result_address %h status %0d",
                 rsp_result_address, rsp_status);
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (exp_res.address != rsp_result_address) begin
            $error("result_address: expected %h, got %h", exp_res.address, rsp_result_address);
            fail_count++;
          end
          if (exp_res.status != rsp_status) begin
            $error("status: expected %0d, got %0d", exp_res.status, rsp_status);
            fail_count++;
          end
        end
      end
      if (req_valid && req_ready) begin
        expected_results.push_back(predict_page_request(req_action, req_num_pages,
                                                        req_free_address));
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ sim/tb_bitmap_page_allocator.sv @@
`timescale 1ns / 100ps

module tb_bitmap_page_allocator import bpa_pkg::*; ();

  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 60;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int COUNT_MAX      = (1 << CNT_W) - 1;

  typedef struct packed {
    logic             action;
    logic [CNT_W-1:0] pages;
  } sent_request_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [CNT_W-1:0]  pages;
  } page_run_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int                    fail_count;
  int                    pending;
  int                    results_checked;
  logic [7:0]            status_seen;

  int                    idle_pct;
  int                    stall_pct;
  int                    hold_asks;
  int                    hold_seen;
  int                    hold_left;
  int                    quiet_cycles;
  int                    requests_sent;
  int                    configs_applied;
  int                    random_pages;
  int unsigned           cur_limit;
  logic [ADDR_W-1:0]     cur_base;
  logic                  track_runs;

  sent_request_t         in_flight[$];
  page_run_t             live_runs[$];
  page_run_t             freed_runs[$];

  bpa_req_if in_req();
  bpa_rsp_if out_rsp();

  bitmap_page_allocator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  page_alloc_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (in_req.valid),
    .req_ready          (in_req.ready),
    .req_action         (in_req.action),
    .req_num_pages      (in_req.num_pages),
    .req_free_address   (in_req.free_address),
    .rsp_valid          (out_rsp.valid),
    .rsp_ready          (out_rsp.ready),
    .rsp_result_address (out_rsp.result_address),
    .rsp_status         (out_rsp.status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .fail_count         (fail_count),
    .pending            (pending),
    .results_checked    (results_checked),
    .status_seen        (status_seen)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_rsp.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_asks) begin
      out_rsp.ready <= 1'b0;
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // remember which allocations are live so frees can target them
  always @(posedge clk) begin : track_results
    sent_request_t req;
    if (rst_n && out_rsp.valid && out_rsp.ready && in_flight.size() > 0) begin
      req = in_flight.pop_front();
      if (track_runs && req.action == ACT_ALLOC && out_rsp.status == ST_OK) begin
        live_runs.push_back(page_run_t'{out_rsp.result_address, req.pages});
      end
    end
  end

  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready) || cfg_we || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_bitmap_page_allocator NOT OK");
      $finish;
    end
  end

  task automatic send_request(input logic act, input int n,
                              input logic [ADDR_W-1:0] addr);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_req.valid <= 1'b0;
      @(negedge clk);
    end
    in_req.valid        <= 1'b1;
    in_req.action       <= act;
    in_req.num_pages    <= CNT_W'(n);
    in_req.free_address <= addr;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    in_flight.push_back(sent_request_t'{act, CNT_W'(n)});
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_req.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_config(input logic ready, input logic [BASE_W-1:0] base, input int pages);
    cfg_write(CFG_READY, CFG_DATA_W'(ready));
    cfg_write(CFG_BASE, CFG_DATA_W'(base));
    cfg_write(CFG_PAGES, CFG_DATA_W'(pages));
    cur_base  = ADDR_W'(base) << PAGE_SHIFT;
    cur_limit = (pages > MAX_PAGES) ? MAX_PAGES : pages;
    configs_applied++;
  endtask

  function automatic logic [BASE_W-1:0] pick_base(input int pages);
    int lim;
    lim = (pages > MAX_PAGES) ? MAX_PAGES : pages;
    if (lim < 1) lim = 1;
    return BASE_W'($urandom_range(0, (1 << BASE_W) - lim));
  endfunction

  // mostly small runs, a few up to the whole region, a few illegal counts
  function automatic int pick_count();
    int          r;
    int unsigned cap;
    if (cur_limit == 0) return $urandom_range(0, COUNT_MAX);
    r = $urandom_range(0, 99);
    if (r < 70) cap = (cur_limit < 8) ? cur_limit : 8;
    else if (r < 90) cap = (cur_limit < 64) ? cur_limit : 64;
    else if (r < 96) cap = cur_limit;
    else if (r < 98) return 0;
    else return $urandom_range(cur_limit + 1, COUNT_MAX);
    return $urandom_range(1, cap);
  endfunction

  task automatic send_random_request();
    int                r;
    int                idx;
    int                k;
    page_run_t         run;
    logic [ADDR_W-1:0] addr;
    r = $urandom_range(0, 99);
    if (live_runs.size() == 0 && r >= 50 && r < 88) r = 0;
    if (r < 50) begin
      send_request(ACT_ALLOC, pick_count(), $urandom());
    end else if (r < 88) begin
      idx = $urandom_range(0, live_runs.size() - 1);
      run = live_runs[idx];
      live_runs.delete(idx);
      if (run.pages > 1 && $urandom_range(0, 3) == 0) begin
        k = $urandom_range(1, run.pages - 1);
        live_runs.push_back(page_run_t'{run.address + (ADDR_W'(k) << PAGE_SHIFT),
                                        run.pages - CNT_W'(k)});
        run.pages = CNT_W'(k);
      end
      send_request(ACT_FREE, int'(run.pages), run.address);
      freed_runs.push_back(run);
      if (freed_runs.size() > 8) void'(freed_runs.pop_front());
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          addr = $urandom();
          if (addr[PAGE_SHIFT-1:0] == '0) addr[0] = 1'b1;
          send_request(ACT_FREE, pick_count(), addr);
        end
        1: begin
          if (freed_runs.size() > 0) begin
            run = freed_runs[$urandom_range(0, freed_runs.size() - 1)];
            send_request(ACT_FREE, int'(run.pages), run.address);
          end else begin
            send_request(ACT_FREE, $urandom_range(0, COUNT_MAX), $urandom());
          end
        end
        2: begin
          addr = cur_base + (ADDR_W'($urandom_range(0, cur_limit)) << PAGE_SHIFT);
          send_request(ACT_FREE, $urandom_range(1, 4), addr);
        end
        default: send_request(ACT_FREE, $urandom_range(0, COUNT_MAX), $urandom());
      endcase
    end
  endtask

  task automatic drain_runs();
    page_run_t run;
    wait_idle();
    while (live_runs.size() > 0) begin
      run = live_runs.pop_front();
      send_request(ACT_FREE, int'(run.pages), run.address);
    end
    wait_idle();
  endtask

  task automatic run_phase(input logic ready, input logic [BASE_W-1:0] base, input int pages,
                           input int idle, input int stall, input int items,
                           input logic pressure);
    apply_config(ready, base, pages);
    idle_pct   = idle;
    stall_pct  = stall;
    track_runs = 1'b1;
    if (pressure) hold_asks <= hold_asks + 1;
    repeat (items) send_random_request();
    drain_runs();
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_READY;
    cfg_wdata           = '0;
    in_req.valid        = 1'b0;
    in_req.action       = ACT_ALLOC;
    in_req.num_pages    = '0;
    in_req.free_address = '0;
    idle_pct            = 0;
    stall_pct           = 0;
    hold_asks           = 0;
    track_runs          = 1'b0;
    cur_limit           = MAX_PAGES;
    cur_base            = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // allocator not enabled yet
    send_request(ACT_ALLOC, 1, '0);
    send_request(ACT_FREE, 1, '0);
    wait_idle();

    apply_config(1'b1, '0, MAX_PAGES);
    send_request(ACT_ALLOC, 0, '1);
    send_request(ACT_ALLOC, MAX_PAGES + 1, '0);
    send_request(ACT_FREE, COUNT_MAX, '0);
    send_request(ACT_FREE, 0, '0);
    send_request(ACT_ALLOC, MAX_PAGES, '0);
    send_request(ACT_ALLOC, 1, '0);
    send_request(ACT_FREE, MAX_PAGES, '0);
    send_request(ACT_ALLOC, 1, '0);
    send_request(ACT_ALLOC, 3, '0);
    send_request(ACT_FREE, 1, 32'h0000_1000);
    send_request(ACT_FREE, 1, 32'h0000_1000);
    send_request(ACT_ALLOC, 2, '0);
    send_request(ACT_FREE, 1, 32'h0000_1001);
    send_request(ACT_FREE, 1, 32'hFFFF_F000);
    send_request(ACT_FREE, 2, 32'h003F_F000);
    send_request(ACT_FREE, 1, 32'h0000_0000);
    send_request(ACT_FREE, 2, 32'h0000_2000);
    send_request(ACT_FREE, 2, 32'h0000_4000);
    wait_idle();

    // top page frame, oversized region: second page wraps to address zero
    apply_config(1'b1, '1, COUNT_MAX);
    send_request(ACT_ALLOC, 1, '0);
    send_request(ACT_ALLOC, 1, '0);
    send_request(ACT_FREE, 1, 32'h0000_0000);
    send_request(ACT_FREE, 2, 32'hFFFF_F000);
    send_request(ACT_FREE, 1, 32'hFFFF_F000);
    wait_idle();

    run_phase(1'b1, '0, MAX_PAGES, 0, 0, 150, 1'b0);
    run_phase(1'b1, pick_base(64), 64, 55, 0, 110, 1'b0);
    run_phase(1'b1, BASE_W'((1 << BASE_W) - MAX_PAGES), MAX_PAGES, 0, 55, 110, 1'b0);
    run_phase(1'b1, pick_base(1), 1, 20, 20, 35, 1'b0);
    random_pages = $urandom_range(1, MAX_PAGES);
    run_phase(1'b1, pick_base(random_pages), random_pages, 20, 20, 110, 1'b0);
    run_phase(1'b0, pick_base(MAX_PAGES), MAX_PAGES, 20, 20, 20, 1'b0);
    run_phase(1'b1, '0, 0, 0, 55, 20, 1'b0);
    run_phase(1'b1, pick_base(MAX_PAGES), MAX_PAGES, 0, 0, 100, 1'b1);
    run_phase(1'b1, '0, COUNT_MAX, 55, 55, 50, 1'b0);

    wait_idle();
    $display("summary: %0d requests under %0d region settings, %0d results checked",
             requests_sent, configs_applied, results_checked);
    $display("summary: status codes returned (one bit per code, ok at right) %b",
             status_seen[6:0]);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_bitmap_page_allocator OK");
    end else begin
      $display("tb_bitmap_page_allocator NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_req_if.sv
hw/rtl/bpa_rsp_if.sv
hw/rtl/bpa_ram.sv
hw/rtl/bpa_datapath.sv
hw/rtl/bpa_ctrl.sv
hw/rtl/bitmap_page_allocator.sv
sim/page_alloc_checker.sv
sim/tb_bitmap_page_allocator.sv
